// File: hdl/ftba_pkg.sv
`timescale 1ns / 1ps
package ftba_pkg;

  localparam int FUNC_W     = 2;
  localparam int SIZE_W     = 4;
  localparam int IDX_W      = 3;
  localparam int STATUS_W   = 3;
  localparam int FREE_W     = 7;
  localparam int FIDX_MAX_W = 6;
  localparam int FREE_MAX   = 127;

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE = 2'd0,
    FN_DELETE = 2'd1,
    FN_READ   = 2'd2,
    FN_WRITE  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_RANGE    = 3'd5,
    ST_TOOLARGE = 3'd6
  } status_e;

  // Result of one pass over the file table.
  typedef struct packed {
    logic                  done;
    logic                  hit;
    logic [FIDX_MAX_W-1:0] hit_idx;
    logic [SIZE_W-1:0]     hit_size;
    logic                  free;
    logic [FIDX_MAX_W-1:0] free_idx;
  } lookup_t;

endpackage

// File: hdl/ftba_ram.sv
`timescale 1ns / 1ps
module ftba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ftba_lookup.sv
`timescale 1ns / 1ps
module ftba_lookup #(
  parameter int NUM_FILES = 16,
  parameter int KEY_BITS  = 56
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [KEY_BITS-1:0]                    key_i,
  input  logic [NUM_FILES-1:0]                   used_i,
  input  logic [KEY_BITS+ftba_pkg::SIZE_W-1:0]   rd_data_i,
  output logic [$clog2(NUM_FILES)-1:0]           rd_addr_o,
  output ftba_pkg::lookup_t                      res_o
);
  import ftba_pkg::*;

  localparam int FIDX_W = $clog2(NUM_FILES);

  logic [FIDX_W:0]   cnt_q;
  logic              busy_q, done_q, hit_q, free_q;
  logic [FIDX_W-1:0] hidx_q, fidx_q, cmp_idx;
  logic [SIZE_W-1:0] hsize_q;
  logic              match;

  // The table RAM has a registered read, so entry cnt-1 is compared
  // while entry cnt is being fetched.
  assign rd_addr_o = cnt_q[FIDX_W-1:0];
  assign cmp_idx   = FIDX_W'(cnt_q - 1'b1);
  assign match     = used_i[cmp_idx] && (rd_data_i[KEY_BITS-1:0] == key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      hidx_q  <= '0;
      fidx_q  <= '0;
      hsize_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q != '0) begin
          if (match && !hit_q) begin
            hit_q   <= 1'b1;
            hidx_q  <= cmp_idx;
            hsize_q <= rd_data_i[KEY_BITS+SIZE_W-1:KEY_BITS];
          end
          if (!used_i[cmp_idx] && !free_q) begin
            free_q <= 1'b1;
            fidx_q <= cmp_idx;
          end
        end
        if (cnt_q == (FIDX_W+1)'(NUM_FILES)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o          = '0;
    res_o.done     = done_q;
    res_o.hit      = hit_q;
    res_o.hit_idx  = FIDX_MAX_W'(hidx_q);
    res_o.hit_size = hsize_q;
    res_o.free     = free_q;
    res_o.free_idx = FIDX_MAX_W'(fidx_q);
  end

endmodule

// File: hdl/file_table_block_allocator.sv
`timescale 1ns / 1ps
// File table with block allocator. Each request names a file by its key and
// creates it, deletes it, or reads or writes one of its data blocks; every
// request returns one response with a status code, the word read (zero unless
// a read succeeds) and the count of free blocks, saturated at 127. Block 0 is
// never handed out. After reset the block runs a clearing pass over every
// entry of the data store and the allocation bitmap before it takes its
// first request. One request at a time is processed: a table lookup runs
// through the shared key comparator; a create then sweeps the allocation
// bitmap one block per cycle until it has enough blocks, a delete clears
// the bitmap bit of each block it frees, and a write or read passes through
// the block map (S_MAP) and the data store (S_ACCESS), a read then waiting
// in S_RDWAIT for the data word. The response is held in S_RESP until it is
// taken.
module file_table_block_allocator #(
  parameter int NUM_FILES       = 16,
  parameter int NUM_BLOCKS      = 128,
  parameter int MAX_FILE_BLOCKS = 8,
  parameter int DATA_BITS       = 64,
  parameter int KEY_BITS        = 56
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ftba_pkg::FUNC_W-1:0]    func_i,
  input  logic [KEY_BITS-1:0]            file_key_i,
  input  logic [ftba_pkg::SIZE_W-1:0]    size_blocks_i,
  input  logic [ftba_pkg::IDX_W-1:0]     block_index_i,
  input  logic [DATA_BITS-1:0]           write_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ftba_pkg::STATUS_W-1:0]  status_o,
  output logic [DATA_BITS-1:0]           read_data_o,
  output logic [ftba_pkg::FREE_W-1:0]    free_blocks_o
);
  import ftba_pkg::*;

  localparam int FIDX_W = $clog2(NUM_FILES);
  localparam int BIDX_W = $clog2(NUM_BLOCKS);
  localparam int MAP_D  = NUM_FILES * MAX_FILE_BLOCKS;
  localparam int MAP_AW = $clog2(MAP_D);
  localparam int KRAM_W = KEY_BITS + SIZE_W;
  localparam int CMP_W  = (BIDX_W > SIZE_W) ? BIDX_W : SIZE_W;
  localparam int SAT_W  = (BIDX_W > FREE_W) ? BIDX_W : FREE_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_ALLOC, S_FREE, S_MAP, S_ACCESS, S_RDWAIT, S_RESP
  } state_e;

  state_e               state_q;
  func_e                func_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [SIZE_W-1:0]    size_q, fsize_q, got_q;
  logic [IDX_W-1:0]     idx_q;
  logic [DATA_BITS-1:0] wdata_q, rdata_q;
  logic [FIDX_W-1:0]    slot_q;
  logic [BIDX_W:0]      blk_q;
  logic [BIDX_W-1:0]    chk_b_q, clr_q, free_cnt_q;
  logic                 chk_v_q, chk_last_q;
  status_e              status_q;
  logic [NUM_FILES-1:0] used_q;

  logic                 accept;
  lookup_t              lk;
  logic [FIDX_W-1:0]    lk_raddr, hit_idx, free_idx;
  logic [KRAM_W-1:0]    kram_rdata;
  logic                 kram_we;
  logic                 map_we;
  logic [MAP_AW-1:0]    map_waddr, map_raddr, base_addr;
  logic [BIDX_W-1:0]    map_rdata;
  logic                 bmp_we, bmp_wdata, bmp_rdata;
  logic [BIDX_W-1:0]    bmp_waddr, bmp_raddr;
  logic                 st_we;
  logic [BIDX_W-1:0]    st_waddr, st_raddr;
  logic [DATA_BITS-1:0] st_wdata, st_rdata;
  logic                 alloc_hit, alloc_last, create_ok;
  logic [SAT_W-1:0]     free_ext;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign hit_idx    = lk.hit_idx[FIDX_W-1:0];
  assign free_idx   = lk.free_idx[FIDX_W-1:0];
  assign base_addr  = MAP_AW'(slot_q) * MAP_AW'(MAX_FILE_BLOCKS);

  // A create passes only when the name is new, a slot is open, enough blocks
  // are free and the size is within the per-file limit.
  assign create_ok = !lk.hit && lk.free
                     && (CMP_W'(free_cnt_q) >= CMP_W'(size_q))
                     && (32'(size_q) <= 32'(MAX_FILE_BLOCKS));

  assign alloc_hit  = (state_q == S_ALLOC) && chk_v_q && !bmp_rdata;
  assign alloc_last = (got_q == size_q - 1'b1);

  ftba_lookup #(
    .NUM_FILES (NUM_FILES),
    .KEY_BITS  (KEY_BITS)
  ) u_lookup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .key_i     (accept ? file_key_i : key_q),
    .used_i    (used_q),
    .rd_data_i (kram_rdata),
    .rd_addr_o (lk_raddr),
    .res_o     (lk)
  );

  ftba_ram #(.WIDTH(KRAM_W), .DEPTH(NUM_FILES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kram_we),
    .waddr_i (free_idx),
    .wdata_i ({size_q, key_q}),
    .raddr_i (lk_raddr),
    .rdata_o (kram_rdata)
  );

  ftba_ram #(.WIDTH(BIDX_W), .DEPTH(MAP_D)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (chk_b_q),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  ftba_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bmp_we),
    .waddr_i (bmp_waddr),
    .wdata_i (bmp_wdata),
    .raddr_i (bmp_raddr),
    .rdata_o (bmp_rdata)
  );

  ftba_ram #(.WIDTH(DATA_BITS), .DEPTH(NUM_BLOCKS)) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Memory port steering. Each state owns the ports it needs.
  always_comb begin
    kram_we   = (state_q == S_LOOKUP) && lk.done && (func_q == FN_CREATE) && create_ok;
    map_we    = alloc_hit;
    map_waddr = base_addr + MAP_AW'(got_q);
    map_raddr = (state_q == S_FREE) ? base_addr + MAP_AW'(got_q)
                                    : base_addr + MAP_AW'(idx_q);
    bmp_we    = 1'b0;
    bmp_wdata = 1'b0;
    bmp_waddr = clr_q;
    bmp_raddr = blk_q[BIDX_W-1:0];
    st_we     = 1'b0;
    st_waddr  = clr_q;
    st_wdata  = '0;
    st_raddr  = map_rdata;
    case (state_q)
      S_CLEAR: begin
        bmp_we = 1'b1;
        st_we  = 1'b1;
      end
      S_ALLOC: begin
        bmp_we    = alloc_hit;
        bmp_wdata = 1'b1;
        bmp_waddr = chk_b_q;
      end
      S_FREE: begin
        bmp_we    = chk_v_q;
        bmp_waddr = map_rdata;
      end
      S_ACCESS: begin
        st_we    = (func_q == FN_WRITE);
        st_waddr = map_rdata;
        st_wdata = wdata_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      free_cnt_q <= BIDX_W'(NUM_BLOCKS - 1);
      used_q     <= '0;
      chk_v_q    <= 1'b0;
      chk_last_q <= 1'b0;
      status_q   <= ST_OK;
      func_q     <= FN_CREATE;
      key_q      <= '0;
      size_q     <= '0;
      fsize_q    <= '0;
      got_q      <= '0;
      idx_q      <= '0;
      wdata_q    <= '0;
      rdata_q    <= '0;
      slot_q     <= '0;
      blk_q      <= '0;
      chk_b_q    <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == BIDX_W'(NUM_BLOCKS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_q  <= func_e'(func_i);
            key_q   <= file_key_i;
            size_q  <= size_blocks_i;
            idx_q   <= block_index_i;
            wdata_q <= write_data_i;
            rdata_q <= '0;
            state_q <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (lk.done) begin
            got_q   <= '0;
            chk_v_q <= 1'b0;
            state_q <= S_RESP;
            if (func_q == FN_CREATE) begin
              slot_q <= free_idx;
              blk_q  <= (BIDX_W+1)'(1);
              if (lk.hit) begin
                status_q <= ST_EXISTS;
              end else if (!lk.free) begin
                status_q <= ST_FULL;
              end else if (CMP_W'(free_cnt_q) < CMP_W'(size_q)) begin
                status_q <= ST_NOSPACE;
              end else if (32'(size_q) > 32'(MAX_FILE_BLOCKS)) begin
                status_q <= ST_TOOLARGE;
              end else begin
                status_q <= ST_OK;
                if (size_q == '0) begin
                  used_q[free_idx] <= 1'b1;
                end else begin
                  state_q <= S_ALLOC;
                end
              end
            end else if (!lk.hit) begin
              status_q <= ST_NOTFOUND;
            end else begin
              slot_q  <= hit_idx;
              fsize_q <= lk.hit_size;
              if (func_q == FN_DELETE) begin
                status_q        <= ST_OK;
                used_q[hit_idx] <= 1'b0;
                free_cnt_q      <= free_cnt_q + BIDX_W'(lk.hit_size);
                if (lk.hit_size != '0) begin
                  state_q <= S_FREE;
                end
              end else if (SIZE_W'(idx_q) >= lk.hit_size) begin
                status_q <= ST_RANGE;
              end else begin
                status_q <= ST_OK;
                state_q  <= S_MAP;
              end
            end
          end
        end
        S_ALLOC: begin
          // Bitmap reads run one block ahead of the free check.
          chk_v_q <= 1'b0;
          if (blk_q < (BIDX_W+1)'(NUM_BLOCKS)) begin
            blk_q   <= blk_q + 1'b1;
            chk_v_q <= 1'b1;
            chk_b_q <= blk_q[BIDX_W-1:0];
          end
          if (alloc_hit) begin
            got_q <= got_q + 1'b1;
            if (alloc_last) begin
              used_q[slot_q] <= 1'b1;
              free_cnt_q     <= free_cnt_q - BIDX_W'(size_q);
              state_q        <= S_RESP;
            end
          end
        end
        S_FREE: begin
          chk_v_q    <= 1'b0;
          chk_last_q <= 1'b0;
          if (got_q < fsize_q) begin
            got_q      <= got_q + 1'b1;
            chk_v_q    <= 1'b1;
            chk_last_q <= (got_q == fsize_q - 1'b1);
          end
          if (chk_v_q && chk_last_q) begin
            state_q <= S_RESP;
          end
        end
        S_MAP: begin
          state_q <= S_ACCESS;
        end
        S_ACCESS: begin
          state_q <= (func_q == FN_READ) ? S_RDWAIT : S_RESP;
        end
        S_RDWAIT: begin
          rdata_q <= st_rdata;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The free count is held at full width and saturated on the way out.
  assign free_ext      = SAT_W'(free_cnt_q);
  assign free_blocks_o = (free_ext > SAT_W'(FREE_MAX)) ? FREE_W'(FREE_MAX)
                                                       : FREE_W'(free_ext);
  assign out_valid_o   = (state_q == S_RESP);
  assign status_o      = status_q;
  assign read_data_o   = rdata_q;

endmodule

// File: tb/file_table_block_allocator_tb.sv
`timescale 1ns / 1ps
module file_table_block_allocator_tb;
  import ftba_pkg::*;

  localparam int NFILES   = 16;
  localparam int NBLOCKS  = 128;
  localparam int MAXBLK   = 8;
  localparam int IDLE_MAX = 10;
  // No request may take longer than this many cycles to be accepted or answered.
  // The limit covers the reset clearing pass, a full bitmap sweep and the
  // longest stall on either side, with a wide margin.
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    func_e       func;
    logic [55:0] key;
    logic [3:0]  size;
    logic [2:0]  idx;
    logic [63:0] wdata;
  } fs_req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] rdata;
    logic [6:0]  nfree;
  } fs_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [FUNC_W-1:0] func_i;
  logic [55:0] file_key_i;
  logic [SIZE_W-1:0] size_blocks_i;
  logic [IDX_W-1:0] block_index_i;
  logic [63:0] write_data_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [63:0] read_data_o;
  logic [FREE_W-1:0] free_blocks_o;

  file_table_block_allocator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .file_key_i   (file_key_i),
    .size_blocks_i(size_blocks_i),
    .block_index_i(block_index_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .free_blocks_o(free_blocks_o)
  );

  // Shadow copy of the file system that the predictor keeps up to date.
  logic        fs_used [NFILES];
  logic [55:0] fs_key  [NFILES];
  logic [3:0]  fs_size [NFILES];
  logic [6:0]  fs_map  [NFILES][MAXBLK];
  logic        fs_busy [NBLOCKS];
  logic [63:0] fs_data [NBLOCKS];

  fs_req_t pending_reqs[$];
  fs_rsp_t expected_rsps[$];
  int      errors;
  int      accepted_reqs;
  int      checked_rsps;
  int      status_seen[7];
  bit      stim_done;

  // A short pool of keys makes duplicates, lookups and deletes hit often.
  logic [55:0] key_pool[8];

  function automatic int free_count();
    int n;
    n = 0;
    for (int b = 1; b < NBLOCKS; b++) if (!fs_busy[b]) n++;
    return (n > 127) ? 127 : n;
  endfunction

  function automatic int find_file(logic [55:0] key);
    for (int i = 0; i < NFILES; i++) if (fs_used[i] && fs_key[i] == key) return i;
    return NFILES;
  endfunction

  // Applies one request to the shadow state and returns the response it earns.
  function automatic fs_rsp_t apply_fs_request(fs_req_t r);
    fs_rsp_t rsp;
    int      e;
    int      slot;
    int      got;
    logic [6:0] phys;
    rsp.status = ST_OK;
    rsp.rdata  = '0;
    e = find_file(r.key);
    case (r.func)
      FN_CREATE: begin
        slot = NFILES;
        for (int i = NFILES - 1; i >= 0; i--) if (!fs_used[i]) slot = i;
        if (e < NFILES) rsp.status = ST_EXISTS;
        else if (slot >= NFILES) rsp.status = ST_FULL;
        else if (free_count() < r.size) rsp.status = ST_NOSPACE;
        else if (r.size > MAXBLK) rsp.status = ST_TOOLARGE;
        else begin
          fs_key[slot]  = r.key;
          fs_size[slot] = r.size;
          got = 0;
          for (int b = 1; b < NBLOCKS && got < r.size; b++) begin
            if (!fs_busy[b]) begin
              fs_busy[b] = 1'b1;
              fs_map[slot][got] = b[6:0];
              got++;
            end
          end
          fs_used[slot] = 1'b1;
        end
      end
      FN_DELETE: begin
        if (e >= NFILES) rsp.status = ST_NOTFOUND;
        else begin
          fs_used[e] = 1'b0;
          for (int j = 0; j < fs_size[e]; j++) fs_busy[fs_map[e][j]] = 1'b0;
        end
      end
      default: begin
        if (e >= NFILES) rsp.status = ST_NOTFOUND;
        else if (r.idx >= fs_size[e]) rsp.status = ST_RANGE;
        else begin
          phys = fs_map[e][r.idx];
          if (r.func == FN_READ) rsp.rdata = fs_data[phys];
          else fs_data[phys] = r.wdata;
        end
      end
    endcase
    rsp.nfree = 7'(free_count());
    return rsp;
  endfunction

  function automatic fs_req_t make_req(func_e f, logic [55:0] key, int size, int idx,
                                       logic [63:0] wdata);
    fs_req_t r;
    r.func  = f;
    r.key   = key;
    r.size  = size[3:0];
    r.idx   = idx[2:0];
    r.wdata = wdata;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [55:0] pick_key();
    if ($urandom_range(0, 9) == 0) return 56'(rand64());
    return key_pool[$urandom_range(0, 7)];
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus: a directed opening, then random traffic that is mostly
  // create/write/read/delete on a small key pool so that the table and the
  // bitmap fill up and drain repeatedly.
  initial begin
    fs_req_t r;
    int      pick;
    for (int i = 0; i < 8; i++) key_pool[i] = 56'(rand64());
    key_pool[0] = '0;
    key_pool[1] = '1;

    pending_reqs.push_back(make_req(FN_READ, key_pool[0], 0, 0, '0));
    pending_reqs.push_back(make_req(FN_DELETE, key_pool[1], 0, 0, '0));
    pending_reqs.push_back(make_req(FN_CREATE, key_pool[0], 8, 0, '0));
    pending_reqs.push_back(make_req(FN_CREATE, key_pool[0], 1, 0, '0));
    pending_reqs.push_back(make_req(FN_CREATE, key_pool[1], 9, 0, '0));
    pending_reqs.push_back(make_req(FN_CREATE, key_pool[1], 15, 0, '0));
    pending_reqs.push_back(make_req(FN_CREATE, key_pool[1], 0, 0, '0));
    pending_reqs.push_back(make_req(FN_READ, key_pool[1], 0, 0, '0));
    pending_reqs.push_back(make_req(FN_WRITE, key_pool[0], 0, 0, '1));
    pending_reqs.push_back(make_req(FN_WRITE, key_pool[0], 0, 7, 64'h0123456789abcdef));
    pending_reqs.push_back(make_req(FN_READ, key_pool[0], 0, 7, '0));
    pending_reqs.push_back(make_req(FN_READ, key_pool[0], 0, 0, '0));
    // The freed blocks keep their data, so a new file sees the old words.
    pending_reqs.push_back(make_req(FN_DELETE, key_pool[0], 0, 0, '0));
    pending_reqs.push_back(make_req(FN_CREATE, key_pool[2], 8, 0, '0));
    pending_reqs.push_back(make_req(FN_READ, key_pool[2], 0, 7, '0));
    // Fill the table so that a further create finds no free entry.
    for (int i = 0; i < 15; i++)
      pending_reqs.push_back(make_req(FN_CREATE, 56'(rand64()) | 56'h1, 8, 0, '0));
    pending_reqs.push_back(make_req(FN_DELETE, key_pool[2], 0, 0, '0));
    pending_reqs.push_back(make_req(FN_DELETE, key_pool[1], 0, 0, '0));

    for (int n = 0; n < 1150; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)
        r = make_req(FN_CREATE, pick_key(),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8),
                     0, '0);
      else if (pick < 40) r = make_req(FN_DELETE, pick_key(), 0, 0, '0);
      else if (pick < 70) r = make_req(FN_WRITE, pick_key(), 0, $urandom_range(0, 7), rand64());
      else r = make_req(FN_READ, pick_key(), 0, $urandom_range(0, 7), rand64());
      // The size field of requests other than create still carries random bits.
      if (r.func != FN_CREATE) r.size = 4'($urandom_range(0, 15));
      pending_reqs.push_back(r);
    end
    stim_done = 1'b1;
  end

  // Reset and end-of-run control.
  initial begin
    int stall;
    int last_activity;
    rst_ni = 1'b0;
    errors = 0;
    accepted_reqs = 0;
    checked_rsps = 0;
    for (int i = 0; i < 7; i++) status_seen[i] = 0;
    for (int i = 0; i < NFILES; i++) begin
      fs_used[i] = 1'b0;
      fs_key[i]  = '0;
      fs_size[i] = '0;
      for (int j = 0; j < MAXBLK; j++) fs_map[i][j] = '0;
    end
    for (int b = 0; b < NBLOCKS; b++) begin
      fs_busy[b] = 1'b0;
      fs_data[b] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Watchdog: counts cycles without any handshake.
    stall = 0;
    last_activity = 0;
    while (!(stim_done && pending_reqs.size() == 0 && !in_valid_i &&
             expected_rsps.size() == 0)) begin
      @(posedge clk_i);
      if (accepted_reqs + checked_rsps != last_activity) begin
        last_activity = accepted_reqs + checked_rsps;
        stall = 0;
      end else begin
        stall++;
      end
      if (stall >= STALL_LIMIT) begin
        $display("timeout: %0d requests accepted, %0d responses outstanding",
                 accepted_reqs, expected_rsps.size());
        $display("file_table_block_allocator_tb failed");
        $finish;
      end
    end
    // Let any stray response show up before closing.
    repeat (200) @(posedge clk_i);
    $display("Ran %0d requests; statuses ok/exists/full/nospace/notfound/range/toolarge:",
             accepted_reqs);
    $display("  %0d/%0d/%0d/%0d/%0d/%0d/%0d", status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0) begin
      $display("file_table_block_allocator_tb passed");
    end else begin
      $display("file_table_block_allocator_tb failed");
    end
    $finish;
  end

  // Request driver: waits a random number of idle cycles before each request,
  // then holds valid and the payload until the handshake.
  int in_gap;
  initial begin
    in_valid_i    = 1'b0;
    func_i        = '0;
    file_key_i    = '0;
    size_blocks_i = '0;
    block_index_i = '0;
    write_data_i  = '0;
    in_gap        = 0;
  end

  always @(posedge clk_i) begin
    fs_req_t r;
    fs_rsp_t rsp;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        r = {func_e'(func_i), file_key_i, size_blocks_i, block_index_i, write_data_i};
        rsp = apply_fs_request(r);
        expected_rsps.push_back(rsp);
        accepted_reqs++;
      end
      if ((!in_valid_i || in_ready_o) && in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if ((!in_valid_i || in_ready_o) && pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_valid_i    <= 1'b1;
        func_i        <= r.func;
        file_key_i    <= r.key;
        size_blocks_i <= r.size;
        block_index_i <= r.idx;
        write_data_i  <= r.wdata;
        // A quarter of the gaps are forced to zero; the rest are drawn from zero to IDLE_MAX.
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
      end else if (!in_valid_i || in_ready_o) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Response monitor: random back-pressure, then a field-by-field compare
  // against the oldest expected response.
  int out_gap;
  initial begin
    out_ready_i = 1'b0;
    out_gap = 0;
  end

  always @(posedge clk_i) begin
    fs_rsp_t exp_rsp;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        checked_rsps++;
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding: status %0d", status_o);
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          status_seen[exp_rsp.status]++;
          if (status_o !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, status_o);
            errors++;
          end
          if (read_data_o !== exp_rsp.rdata) begin
            $error("read_data: expected %h, got %h", exp_rsp.rdata, read_data_o);
            errors++;
          end
          if (free_blocks_o !== exp_rsp.nfree) begin
            $error("free_blocks: expected %0d, got %0d", exp_rsp.nfree, free_blocks_o);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_ready_i <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i)
          out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
      end
    end
  end

endmodule

// File: filelist.f
hdl/ftba_pkg.sv
hdl/ftba_ram.sv
hdl/ftba_lookup.sv
hdl/file_table_block_allocator.sv
tb/file_table_block_allocator_tb.sv
